>>> hw/rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; used by all files under hw/rtl.
`default_nettype none

package modexp_pkg;

    // Field widths
    localparam int BASE_W  = 63;
    localparam int EXP_W   = 63;
    localparam int POWER_W = 30;

    // Default number of exponent bits scanned
    localparam int EXP_BITS_DEFAULT = 63;

    // Modulus and derived constants, worked out at elaboration
    localparam logic [63:0] PRIME_64   = 64'd1000000007;
    localparam logic [63:0] FOLD30_64  = (64'd1 << 30) % PRIME_64;
    localparam logic [63:0] FOLD60_64  = (64'd1 << 60) % PRIME_64;
    localparam logic [63:0] BARRETT_64 = (64'd1 << 60) / PRIME_64;

    localparam logic [29:0] PRIME     = PRIME_64[29:0];
    localparam logic [29:0] FOLD30    = FOLD30_64[29:0];   // 2^30 mod prime
    localparam logic [29:0] FOLD60    = FOLD60_64[29:0];   // 2^60 mod prime
    localparam logic [30:0] BARRETT_M = BARRETT_64[30:0];  // floor(2^60 / prime)

    // Pipeline phase of one modular multiply round
    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ROUND,
        ST_DONE
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture input word, acc = 1
        logic reduce;    // multiplier lanes fold the base instead of squaring
        logic wb;        // write back lane results
        logic out_load;  // move accumulator into output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic exp_zero;  // no exponent bits left
        logic exp_last;  // current round is the last with a set bit
    } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/modexp_mulred.sv
// Pipelined 30x30 modular multiply with Barrett reduction mod the prime.
// Depends on modexp_pkg. Product, estimate and q*P stages are registered.
`default_nettype none

module modexp_mulred (
    input  wire logic        aclk,
    input  wire logic [29:0] op_a,
    input  wire logic [29:0] op_b,
    input  wire logic [33:0] addend,
    output logic      [29:0] result
);

    logic [59:0] prod_next;
    logic [59:0] prod_reg;
    logic [61:0] est_next;
    logic [61:0] est_reg;
    logic [31:0] low1_reg;
    logic [30:0] quot;
    logic [60:0] qp_full;
    logic [31:0] qp_reg;
    logic [31:0] low2_reg;
    logic [31:0] rem_raw;
    logic [32:0] rem_m1;
    logic [32:0] rem_m2;

    // Stage 1: product plus addend, below 2^60
    assign prod_next = 60'(op_a) * 60'(op_b) + 60'(addend);

    // Stage 2: quotient estimate from top bits
    assign est_next = 62'(prod_reg[59:29]) * 62'(modexp_pkg::BARRETT_M);

    // Stage 3: quotient times prime, low bits suffice since remainder < 3P
    assign quot    = est_reg[61:31];
    assign qp_full = 61'(quot) * 61'(modexp_pkg::PRIME);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        est_reg  <= est_next;
        low1_reg <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        low2_reg <= low1_reg;
    end

    // Stage 4: remainder and up to two corrections
    assign rem_raw = low2_reg - qp_reg;
    assign rem_m1  = 33'(rem_raw) - 33'(modexp_pkg::PRIME);
    assign rem_m2  = 33'(rem_raw) - 33'({modexp_pkg::PRIME, 1'b0});

    always_comb begin
        priority if (!rem_m2[32]) begin
            result = rem_m2[29:0];
        end else if (!rem_m1[32]) begin
            result = rem_m1[29:0];
        end else begin
            result = rem_raw[29:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/modexp_datapath.sv
// Datapath: base fold, square and multiply lanes, exponent shifter, output word.
// Depends on modexp_pkg and modexp_mulred.
`default_nettype none

module modexp_datapath #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire modexp_pkg::dp_cmd_t               cmd,
    input  wire logic [modexp_pkg::BASE_W-1:0]     base_in,
    input  wire logic [modexp_pkg::EXP_W-1:0]      exp_in,
    output modexp_pkg::dp_sts_t                    sts,
    output logic      [modexp_pkg::POWER_W-1:0]    power
);

    logic [modexp_pkg::BASE_W-1:0] base_reg;
    logic [modexp_pkg::EXP_W-1:0]  exp_reg;
    logic [modexp_pkg::EXP_W-1:0]  exp_mask;
    logic [29:0]                   sq_reg;
    logic [29:0]                   acc_reg;
    logic [29:0]                   power_reg;
    logic [29:0]                   sq_a;
    logic [29:0]                   sq_b;
    logic [33:0]                   sq_add;
    logic [29:0]                   sq_res;
    logic [29:0]                   acc_res;

    // Exponent bits at or above EXP_BITS are never scanned
    for (genvar i = 0; i < modexp_pkg::EXP_W; i++) begin : g_mask
        assign exp_mask[i] = (i < EXP_BITS);
    end

    // Base fold: hi*2^60 + mid*2^30 + lo == hi*F60 + mid*F30 + lo, below 2^58
    always_comb begin
        if (cmd.reduce) begin
            sq_a   = base_reg[59:30];
            sq_b   = modexp_pkg::FOLD30;
            sq_add = 34'(base_reg[62:60]) * 34'(modexp_pkg::FOLD60)
                   + 34'(base_reg[29:0]);
        end else begin
            sq_a   = sq_reg;
            sq_b   = sq_reg;
            sq_add = '0;
        end
    end

    modexp_mulred u_sq_lane (
        .aclk   (aclk),
        .op_a   (sq_a),
        .op_b   (sq_b),
        .addend (sq_add),
        .result (sq_res)
    );

    modexp_mulred u_acc_lane (
        .aclk   (aclk),
        .op_a   (acc_reg),
        .op_b   (sq_reg),
        .addend ('0),
        .result (acc_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= base_in;
            exp_reg  <= exp_in & exp_mask;
            acc_reg  <= 30'd1;
        end else if (cmd.wb) begin
            sq_reg <= sq_res;
            if (!cmd.reduce) begin
                exp_reg <= exp_reg >> 1;
                if (exp_reg[0]) begin
                    acc_reg <= acc_res;
                end
            end
        end
        if (cmd.out_load) begin
            power_reg <= acc_reg;
        end
    end

    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_last = (exp_reg[modexp_pkg::EXP_W-1:1] == '0);
    assign power        = power_reg;

endmodule

`default_nettype wire

>>> hw/rtl/modexp_ctrl.sv
// Controller FSM: sequences base fold and exponent rounds, owns handshakes.
// Depends on modexp_pkg.
`default_nettype none

module modexp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire modexp_pkg::dp_sts_t  sts,
    output modexp_pkg::dp_cmd_t       cmd
);

    modexp_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       busy;
    logic       out_free;

    assign busy     = (state_reg == modexp_pkg::ST_REDUCE) ||
                      (state_reg == modexp_pkg::ST_ROUND);
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            modexp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (phase_reg == modexp_pkg::PHASE_LAST) begin
                    state_next = sts.exp_zero ? modexp_pkg::ST_DONE
                                              : modexp_pkg::ST_ROUND;
                end
            end
            modexp_pkg::ST_ROUND: begin
                if (phase_reg == modexp_pkg::PHASE_LAST && sts.exp_last) begin
                    state_next = modexp_pkg::ST_DONE;
                end
            end
            modexp_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = modexp_pkg::ST_IDLE;
                end
            end
            default: state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = (state_reg == modexp_pkg::ST_IDLE);
        cmd.load     = (state_reg == modexp_pkg::ST_IDLE) && s_tvalid;
        cmd.reduce   = (state_reg == modexp_pkg::ST_REDUCE);
        cmd.wb       = busy && (phase_reg == modexp_pkg::PHASE_LAST);
        cmd.out_load = (state_reg == modexp_pkg::ST_DONE) && out_free;
    end

    assign phase_next = busy ? phase_reg + 2'd1 : 2'd0;

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= modexp_pkg::ST_IDLE;
            phase_reg    <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// Modular exponentiation top level: base^exponent mod 1000000007.
// Depends on modexp_pkg, modexp_ctrl, modexp_datapath, modexp_mulred.
//
// Each input word carries a base and an exponent; one output word returns
// base^exponent mod 1000000007 (exponent zero gives 1). The base is first
// folded below the prime, then the exponent is scanned right to left, one bit
// per round, squaring the running base and multiplying it into the accumulator
// when the bit is set. Both products share one round through two pipelined
// Barrett multiply lanes, so the loop through that pipeline sets the latency.
// Scanning stops after the highest set exponent bit, so the time from accept
// to output valid grows with the position of the top set bit. One item is in
// flight at a time; a new word is accepted once the previous result sits in
// the output register, even if it has not been taken yet. Exponent bits at
// or above EXP_BITS are ignored.
`default_nettype none

module modular_exponentiation #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input word
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [62:0] base, [125:63] exponent, rest zero
    // Result word
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [31:0]  m_tdata    // [29:0] power, rest zero
);

    modexp_pkg::dp_cmd_t cmd;
    modexp_pkg::dp_sts_t sts;
    logic [modexp_pkg::POWER_W-1:0] power;

    // Sequencing and handshakes
    modexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic: fold, square/multiply lanes, output register
    modexp_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .cmd     (cmd),
        .base_in (s_tdata[62:0]),
        .exp_in  (s_tdata[125:63]),
        .sts     (sts),
        .power   (power)
    );

    assign m_tdata = {2'b00, power};

`ifndef SYNTHESIS
    // Result is always fully reduced
    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:0] < modexp_pkg::PRIME))
        else $error("power not reduced below prime");

    // Only one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // Loading the output register raises valid and returns the controller to idle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_tvalid && !s_tready == 1'b0))
        else $error("output load did not return to idle with valid result");
`endif

endmodule

`default_nettype wire

>>> sim/modular_exponentiation_tb.sv
// Self-checking testbench for modular_exponentiation (base^exponent mod 1000000007).
// Depends on modexp_pkg and the RTL under hw/rtl; needs no files or arguments.
// Directed corner words, then random words, with random stalls on both streams.
`timescale 1ns / 100ps

module modular_exponentiation_tb;

    localparam int          SCAN_BITS    = modexp_pkg::EXP_BITS_DEFAULT;
    localparam logic [63:0] MODULUS      = 64'd1000000007;
    localparam logic [62:0] FIELD_MAX    = {63{1'b1}};
    localparam logic [62:0] PRIME_63     = 63'd1000000007;
    localparam int          RANDOM_WORDS = 630;
    localparam int          QUIET_WORDS  = 120;   // tail with no idling
    localparam int          DRAIN_CYCLES = 300;   // exceeds the worst-case latency

    // Expected powers, oldest first, computed as each word is accepted.
    class power_scoreboard;
        logic [29:0] power_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Right-to-left square-and-multiply over SCAN_BITS exponent bits.
        function logic [29:0] modpow_prime(logic [62:0] base, logic [62:0] exponent);
            logic [63:0] square;
            logic [63:0] acc;
            square = {1'b0, base} % MODULUS;
            acc    = 64'd1;
            for (int i = 0; i < SCAN_BITS && i < 64; i++) begin
                if (i < 63 && exponent[i])
                    acc = (acc * square) % MODULUS;
                square = (square * square) % MODULUS;
            end
            return acc[29:0];
        endfunction

        function void note_operands(logic [62:0] base, logic [62:0] exponent);
            power_q = {power_q, modpow_prime(base, exponent)};
        endfunction

        function void check_power(logic [29:0] got);
            logic [29:0] want;
            if (power_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %0d",
                         $time, got);
                errors++;
            end else begin
                want = power_q.pop_front();
                if (got !== want) begin
                    $display("%0t: power mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return power_q.size();
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // [62:0] base, [125:63] exponent, rest zero
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;         // [29:0] power, rest zero

    bit              quiet_tail = 1'b0;
    power_scoreboard sb         = new();

    modular_exponentiation #(
        .EXP_BITS (SCAN_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Hard stop, several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    // Random value whose top set bit is at position width-1.
    function automatic logic [62:0] rand_width(int width);
        logic [63:0] mask;
        logic [63:0] r;
        mask = (64'd1 << width) - 64'd1;
        r    = {1'b0, rand63()} & mask;
        r[width-1] = 1'b1;
        return r[62:0];
    endfunction

    // Present one word, optionally after an idle burst, and hold until accepted.
    // valid stays high into the next word when no burst follows.
    task automatic send_word(input logic [62:0] base, input logic [62:0] exponent,
                             input bit allow_idle);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, exponent, base};
        do @(posedge aclk); while (!s_tready);
        sb.note_operands(base, exponent);
    endtask

    // Result side: check accepted words, drop tready in random bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_power(m_tdata[29:0]);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= (stall_left == 0);
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [62:0] base;
        logic [62:0] exponent;
        logic [63:0] multiple;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: zero exponent, zero and prime-multiple bases,
        // full-width fields, single top bit, alternating bit patterns.
        send_word(63'd0, 63'd0, 1'b1);
        send_word(FIELD_MAX, 63'd0, 1'b1);
        send_word(PRIME_63, 63'd0, 1'b1);
        send_word(63'd0, 63'd1, 1'b1);
        send_word(63'd0, FIELD_MAX, 1'b1);
        send_word(63'd1, FIELD_MAX, 1'b1);
        send_word(PRIME_63, 63'd1, 1'b1);
        send_word(PRIME_63 * 2, 63'd12345, 1'b1);
        send_word(PRIME_63 * 63'd4000000000, FIELD_MAX, 1'b1);
        send_word(FIELD_MAX, FIELD_MAX, 1'b1);
        send_word(FIELD_MAX, 63'd1, 1'b1);
        send_word(FIELD_MAX, 63'd2, 1'b1);
        send_word(PRIME_63 - 1, 63'd2, 1'b1);
        send_word(PRIME_63 - 1, 63'd3, 1'b1);
        send_word(PRIME_63 + 1, FIELD_MAX, 1'b1);
        send_word(63'd2, 63'd1 << 62, 1'b1);
        send_word(63'd3, 63'd1 << 62, 1'b1);
        send_word(63'd2, 63'd30, 1'b1);
        send_word(63'd5, 63'h5555_5555_5555_5555, 1'b1);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(63'h5555_5555_5555_5555, 63'd1000000006, 1'b0);
        send_word(63'd2, FIELD_MAX, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet_tail = 1'b1;

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: base = rand63();
                5:             base = 63'($urandom_range(0, 15));
                6, 7: begin
                    // near a multiple of the prime, including exact multiples
                    multiple = MODULUS * 64'($urandom_range(0, 32'h7FFF_FFFF));
                    base     = multiple[62:0] + 63'($urandom_range(0, 2))
                               - 63'($urandom_range(0, 1));
                end
                default:       base = 63'($urandom_range(0, 32'h3FFF_FFFF));
            endcase

            // Latency follows the top set exponent bit, so most exponents
            // are of random width and only some span the full field.
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: exponent = rand_width($urandom_range(1, 63));
                6:                exponent = 63'($urandom_range(0, 3));
                7:                exponent = rand63();
                8:                exponent = 63'd1 << $urandom_range(0, 62);
                default:          exponent = rand_width($urandom_range(1, 63)) |
                                             (FIELD_MAX >> $urandom_range(0, 62));
            endcase

            send_word(base, exponent, !quiet_tail);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
